FILE: rtl/bgc_pkg.sv
// Shared types, codes and defaults for the button gesture classifier.
package bgc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int DIR_W         = 3;

    // Item kinds
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_IDLE   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_SELECT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RETURN = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP     = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DN     = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DOUBLE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_PRESS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE      = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_DOUBLE_WINDOW = 16'd250;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS    = 16'd600;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE      = 16'd8;

    typedef logic [DIR_W-1:0] t_dir;

    typedef struct packed {
        logic [CFG_W-1:0] double_window_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic             func;
        logic [NOW_W-1:0] now_ms;
        logic             nav_pressed;
        logic             select_pressed;
    } t_item;

endpackage

FILE: rtl/bgc_intf.sv
// Channel interfaces: input items, result items and configuration writes.
interface bgc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [bgc_pkg::NOW_W-1:0] now_ms;
    logic                      nav_pressed;
    logic                      select_pressed;

    modport source (output valid, func, now_ms, nav_pressed, select_pressed, input ready);
    modport sink   (input valid, func, now_ms, nav_pressed, select_pressed, output ready);
endinterface

interface bgc_out_if;
    logic          valid;
    logic          ready;
    bgc_pkg::t_dir direction;

    modport source (output valid, direction, input ready);
    modport sink   (input valid, direction, output ready);
endinterface

interface bgc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bgc_pkg::CFG_IDX_W-1:0] index;
    logic [bgc_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/button_gesture_classifier.sv
// Top level of the button gesture classifier: input register, core, result register.
//
// Usage:
//   i_cmd carries one item per transfer: an edge event on the navigation
//   button (func 0, nav_pressed is the level) or a poll (func 1,
//   select_pressed is the level), each with a millisecond timestamp.
//   o_res carries one direction code per poll; edge events produce nothing.
//   i_cfg writes the double window, long press and debounce registers
//   (index 0, 1, 2; index 3 is ignored). It is always ready; the user must
//   write it only while no item is in flight; the block does not enforce this.
// Pipeline and rate:
//   An accepted item is held in the input register; as it moves on, the
//   core's compare logic updates the gesture state and, for a poll, loads
//   the result register, which drives o_res.valid. One item per cycle is
//   sustained while no poll is held behind a stalled result.
// Stalls and reset:
//   When o_res is stalled with a result waiting, edge events still pass
//   through; a poll holds in the input register, and i_cmd.ready drops,
//   until the result register frees. Reset is synchronous, active low: it
//   empties both registers, restores register defaults and clears the
//   gesture state (timestamps to zero).
module button_gesture_classifier #(
    parameter int TIME_BITS = bgc_pkg::TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bgc_in_if.sink    i_cmd,
    bgc_out_if.source o_res,
    bgc_cfg_if.sink   i_cfg
);

    bgc_pkg::t_cfg  w_cfg;
    bgc_pkg::t_dir  w_dir;
    bgc_pkg::t_item r_item;
    logic           r_item_valid;
    logic           r_out_valid, n_out_valid;
    bgc_pkg::t_dir  r_out_dir;
    logic           w_adv;

    bgc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // The input register moves on when its item is an edge (no result) or
    // when the result register is empty or being drained this cycle.
    assign w_adv = r_item_valid
                   && ((r_item.func == bgc_pkg::FUNC_EDGE) || !r_out_valid || o_res.ready);

    assign i_cmd.ready = !r_item_valid || w_adv;

    bgc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_dir   (w_dir)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_item_valid <= i_cmd.valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_item.func           <= i_cmd.func;
            r_item.now_ms         <= i_cmd.now_ms;
            r_item.nav_pressed    <= i_cmd.nav_pressed;
            r_item.select_pressed <= i_cmd.select_pressed;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_adv && (r_item.func == bgc_pkg::FUNC_POLL)) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && (r_item.func == bgc_pkg::FUNC_POLL)) begin
            r_out_dir <= w_dir;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.direction = r_out_dir;

    // A waiting result is never dropped while the receiver stalls.
    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid)
        else $error("stalled result lost");

    // Input backpressure only comes from a held poll behind a full result register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> (r_item_valid && (r_item.func == bgc_pkg::FUNC_POLL)
                          && r_out_valid && !o_res.ready))
        else $error("input stalled without cause");

endmodule

FILE: rtl/bgc_cfg_regs.sv
// Configuration register file: window, long-press and debounce times.
module bgc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bgc_cfg_if.sink       i_cfg,
    output bgc_pkg::t_cfg o_cfg
);

    bgc_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_window_ms <= bgc_pkg::RST_DOUBLE_WINDOW;
            r_cfg.long_press_ms    <= bgc_pkg::RST_LONG_PRESS;
            r_cfg.debounce_ms      <= bgc_pkg::RST_DEBOUNCE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bgc_pkg::CFG_IDX_DOUBLE_WINDOW: r_cfg.double_window_ms <= i_cfg.data;
                bgc_pkg::CFG_IDX_LONG_PRESS:    r_cfg.long_press_ms    <= i_cfg.data;
                bgc_pkg::CFG_IDX_DEBOUNCE:      r_cfg.debounce_ms      <= i_cfg.data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

endmodule

FILE: rtl/bgc_core.sv
// Gesture state and classification of one edge event or poll.
module bgc_core #(
    parameter int TIME_BITS = bgc_pkg::TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  bgc_pkg::t_item i_item,
    input  bgc_pkg::t_cfg  i_cfg,
    output bgc_pkg::t_dir  o_dir
);

    logic [TIME_BITS-1:0] r_last, n_last;
    logic [TIME_BITS-1:0] r_press, n_press;
    logic [TIME_BITS-1:0] r_first, n_first;
    logic r_down, n_down;
    logic r_wait, n_wait;
    logic r_dbl, n_dbl;
    logic r_long_seen, n_long_seen;
    logic r_long_fired, n_long_fired;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_el_last, w_el_press, w_el_first;
    logic [TIME_BITS-1:0] w_dw, w_lp, w_deb;
    logic                 w_bounce;

    // Timestamps wrap at TIME_BITS; the cast truncates or zero-extends.
    assign w_now      = TIME_BITS'(i_item.now_ms);
    assign w_el_last  = w_now - r_last;
    assign w_el_press = w_now - r_press;
    assign w_el_first = w_now - r_first;
    assign w_dw       = TIME_BITS'(i_cfg.double_window_ms);
    assign w_lp       = TIME_BITS'(i_cfg.long_press_ms);
    assign w_deb      = TIME_BITS'(i_cfg.debounce_ms);
    assign w_bounce   = (w_el_last < w_deb);

    always_comb begin
        n_last       = r_last;
        n_press      = r_press;
        n_first      = r_first;
        n_down       = r_down;
        n_wait       = r_wait;
        n_dbl        = r_dbl;
        n_long_seen  = r_long_seen;
        n_long_fired = r_long_fired;
        o_dir        = bgc_pkg::DIR_IDLE;

        if (i_item.func == bgc_pkg::FUNC_EDGE) begin
            if (!w_bounce) begin
                n_last = w_now;
                if (i_item.nav_pressed) begin
                    n_down  = 1'b1;
                    n_press = w_now;
                end else begin
                    n_down = 1'b0;
                    if (r_long_seen) begin
                        // long hold already reported: no release recorded
                        n_long_seen = 1'b0;
                        n_wait      = 1'b0;
                    end else if (w_el_press < w_lp) begin
                        if (r_wait && (w_el_first <= w_dw)) begin
                            n_dbl  = 1'b1;
                            n_wait = 1'b0;
                        end else begin
                            n_wait  = 1'b1;
                            n_first = w_now;
                        end
                    end else begin
                        n_wait = 1'b0;
                    end
                end
            end
        end else if (i_item.select_pressed) begin
            o_dir = bgc_pkg::DIR_SELECT;
        end else if (r_down) begin
            if (!r_long_fired && (w_el_press > w_lp)) begin
                n_long_fired = 1'b1;
                n_wait       = 1'b0;
                n_dbl        = 1'b0;
                n_long_seen  = 1'b1;
                o_dir        = bgc_pkg::DIR_RETURN;
            end
        end else begin
            n_long_fired = 1'b0;
            if (r_dbl) begin
                n_dbl  = 1'b0;
                n_wait = 1'b0;
                o_dir  = bgc_pkg::DIR_UP;
            end else if (r_wait && (w_el_first > w_dw)) begin
                n_wait = 1'b0;
                o_dir  = bgc_pkg::DIR_DN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= '0;
            r_press      <= '0;
            r_first      <= '0;
            r_down       <= 1'b0;
            r_wait       <= 1'b0;
            r_dbl        <= 1'b0;
            r_long_seen  <= 1'b0;
            r_long_fired <= 1'b0;
        end else if (i_step) begin
            r_last       <= n_last;
            r_press      <= n_press;
            r_first      <= n_first;
            r_down       <= n_down;
            r_wait       <= n_wait;
            r_dbl        <= n_dbl;
            r_long_seen  <= n_long_seen;
            r_long_fired <= n_long_fired;
        end
    end

    // A reported long hold stays marked until the button is released.
    a_long_seen_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_seen |-> (r_down && r_long_fired))
        else $error("long_seen set without a held, reported press");

    // A bounced edge leaves every piece of state untouched.
    a_bounce_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.func == bgc_pkg::FUNC_EDGE) && w_bounce)
        |=> ($stable(r_last) && $stable(r_press) && $stable(r_first) && $stable(r_down)
             && $stable(r_wait) && $stable(r_dbl) && $stable(r_long_seen)))
        else $error("bounced edge changed state");

    // Back is reported once and arms the long-hold marks.
    a_back_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.func == bgc_pkg::FUNC_POLL) && (o_dir == bgc_pkg::DIR_RETURN))
        |=> (r_long_fired && r_long_seen && !r_dbl && !r_wait))
        else $error("back reported without arming long-hold state");

endmodule
